/* design/trie_prefix_origin_lookup_top_defines.svh */
// Assertion macros for the prefix origin lookup block.
// Used by trie_prefix_origin_lookup_top; expects clk_i and rst_ni in scope.
`ifndef TRIE_PREFIX_ORIGIN_LOOKUP_TOP_DEFINES_SVH
`define TRIE_PREFIX_ORIGIN_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TPOL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define TPOL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tpol_pkg.sv */
// Shared types and constants of the prefix origin lookup block.
// Used by tpol_ctrl, tpol_dp and trie_prefix_origin_lookup_top; no dependencies.
package tpol_pkg;

  localparam int unsigned NODE_DEPTH_DEF = 4096;
  localparam int unsigned ROOT_COUNT     = 256;
  localparam int unsigned ROOT_AW        = 8;
  localparam int unsigned IDX_W          = 12;
  localparam int unsigned WALK_LIMIT     = 25;
  localparam int unsigned VISIT_W        = $clog2(WALK_LIMIT);
  localparam logic [5:0]  FULL_LENGTH    = 6'd32;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_NODE_WR = 2'd1,
    OP_ROOT_WR = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [31:0]      lookup_address;
    logic [IDX_W-1:0] node_index;
    logic [31:0]      node_prefix;
    logic [5:0]       node_length;
    logic [15:0]      node_origin;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic [7:0]       root_slot;
    logic [IDX_W-1:0] root_node;
  } in_item_t;

  typedef struct packed {
    logic [15:0] origin_asn;
    logic        found;
  } out_item_t;

  // One trie node as held in the node memory
  typedef struct packed {
    logic [31:0]      prefix;
    logic [5:0]       length;
    logic [15:0]      origin;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic root_step;
    logic node_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic root_end;
    logic node_stop;
  } sts_t;

endpackage

/* design/tpol_dp.sv */
// Datapath of the prefix origin lookup: root table, node memory, node compare
// and the result register. Depends on tpol_pkg.
module tpol_dp #(
  parameter int unsigned NODE_DEPTH = tpol_pkg::NODE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpol_pkg::cmd_t      cmd_i,
  input  tpol_pkg::in_item_t  in_data_i,
  output tpol_pkg::sts_t      sts_o,
  output tpol_pkg::out_item_t out_data_o
);

  localparam int unsigned NODE_AW = $clog2(NODE_DEPTH);

  // Node index that points at a stored node
  function automatic logic idx_live(input logic [tpol_pkg::IDX_W-1:0] idx);
    return (idx != '0) && (32'(idx) < NODE_DEPTH);
  endfunction

  logic [tpol_pkg::IDX_W-1:0] root_mem [tpol_pkg::ROOT_COUNT];
  logic [tpol_pkg::ROOT_COUNT-1:0] root_vld_q;
  logic [tpol_pkg::IDX_W-1:0] root_rd_q;
  logic                       root_vld_rd_q;

  tpol_pkg::node_t node_mem [NODE_DEPTH];
  tpol_pkg::node_t node_rd_q;

  logic [31:0]         addr_q;
  logic [15:0]         origin_q;
  tpol_pkg::out_item_t out_q;

  logic                       is_node_wr;
  logic                       is_root_wr;
  logic [tpol_pkg::IDX_W-1:0] root_idx;
  logic [5:0]                 len_c;
  logic [31:0]                mask;
  logic                       match;
  logic [4:0]                 bit_sel;
  logic [tpol_pkg::IDX_W-1:0] next_idx;
  logic [tpol_pkg::IDX_W-1:0] rd_idx;
  logic [tpol_pkg::ROOT_AW-1:0] top_byte;

  assign is_node_wr = cmd_i.accept &&
                      (in_data_i.opcode == tpol_pkg::OP_NODE_WR) &&
                      idx_live(in_data_i.node_index);
  assign is_root_wr = cmd_i.accept && (in_data_i.opcode == tpol_pkg::OP_ROOT_WR);
  assign top_byte   = in_data_i.lookup_address[31 -: tpol_pkg::ROOT_AW];

  // Root entry, null when the slot was never written
  assign root_idx = root_vld_rd_q ? root_rd_q : '0;

  // Compare the address against the current node
  always_comb begin
    len_c    = (node_rd_q.length > tpol_pkg::FULL_LENGTH) ? tpol_pkg::FULL_LENGTH
                                                          : node_rd_q.length;
    mask     = ~(32'hFFFF_FFFF >> len_c);
    match    = (addr_q & mask) == node_rd_q.prefix;
    bit_sel  = 5'd31 - len_c[4:0];
    next_idx = addr_q[bit_sel] ? node_rd_q.right : node_rd_q.left;
    rd_idx   = cmd_i.root_step ? root_idx : next_idx;
  end

  assign sts_o.root_end  = !idx_live(root_idx);
  assign sts_o.node_stop = !match || (len_c == tpol_pkg::FULL_LENGTH) || !idx_live(next_idx);

  // Root slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_vld_q <= '0;
    end else if (is_root_wr) begin
      root_vld_q[in_data_i.root_slot] <= 1'b1;
    end
  end

  // Root table: write and registered read on the accepted beat
  always_ff @(posedge clk_i) begin
    if (is_root_wr) begin
      root_mem[in_data_i.root_slot] <= in_data_i.root_node;
    end
    if (cmd_i.accept) begin
      root_rd_q     <= root_mem[top_byte];
      root_vld_rd_q <= root_vld_q[top_byte];
    end
  end

  // Node memory: write on the accepted beat, read one node per walk step
  always_ff @(posedge clk_i) begin
    if (is_node_wr) begin
      node_mem[NODE_AW'(in_data_i.node_index)] <= '{
        prefix: in_data_i.node_prefix,
        length: in_data_i.node_length,
        origin: in_data_i.node_origin,
        left:   in_data_i.left_child,
        right:  in_data_i.right_child
      };
    end
    if (cmd_i.root_step || cmd_i.node_step) begin
      node_rd_q <= node_mem[NODE_AW'(rd_idx)];
    end
  end

  // Walk state: address and last nonzero origin
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q   <= in_data_i.lookup_address;
      origin_q <= '0;
    end else if (cmd_i.node_step && match && (node_rd_q.origin != '0)) begin
      origin_q <= node_rd_q.origin;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.origin_asn <= origin_q;
      out_q.found      <= (origin_q != '0);
    end
  end

  assign out_data_o = out_q;

endmodule

/* design/tpol_ctrl.sv */
// Controller of the prefix origin lookup: walk sequencer, visit counter and
// output valid. Depends on tpol_pkg.
module tpol_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     opcode_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tpol_pkg::cmd_t cmd_o,
  input  tpol_pkg::sts_t sts_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_NODE = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [tpol_pkg::VISIT_W-1:0] visits_q, visits_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence one item at a time
  always_comb begin
    state_d  = state_q;
    visits_d = visits_q;
    cmd_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && (opcode_i == tpol_pkg::OP_LOOKUP)) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        visits_d        = '0;
        state_d         = sts_i.root_end ? ST_DONE : ST_NODE;
      end
      ST_NODE: begin
        cmd_o.node_step = 1'b1;
        visits_d        = visits_q + 1'b1;
        if (sts_i.node_stop ||
            (visits_q == tpol_pkg::VISIT_W'(tpol_pkg::WALK_LIMIT - 1))) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result beat until the receiver takes it
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      visits_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      visits_q    <= visits_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* design/trie_prefix_origin_lookup_top.sv */
// Longest-prefix origin lookup over a binary prefix trie held in on-chip memory.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat carries a lookup,
// a node write or a root slot write, chosen by the opcode. Writes finish in the
// cycle they are accepted and give no result; the next beat may follow at once.
// A lookup reads its root slot, then walks one trie node per cycle through a
// single-port read of the node memory, and gives one result beat on the output
// channel (out_valid_o / out_stall_i / out_data_o) with the last nonzero origin.
// A lookup registers its root slot entry, reads the root node, visits 0 to 25 nodes
// and loads the result register, which then raises result valid; the next beat
// is taken in the cycle after the result is loaded, so a lookup holds the input
// channel until then. The node memory read per step sets the walk rate.
// The result sits in an output register, so a stalled receiver holds it while
// the next beat is accepted; a lookup that finishes then waits for that register.
// Reset clears the root table (valid bit per slot) and the control state; node
// entries must be written before a walk reaches them.
// Files: tpol_pkg, tpol_ctrl, tpol_dp, trie_prefix_origin_lookup_top_defines.svh.
`include "trie_prefix_origin_lookup_top_defines.svh"

module trie_prefix_origin_lookup_top #(
  parameter int unsigned NODE_DEPTH = tpol_pkg::NODE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tpol_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tpol_pkg::out_item_t out_data_o
);

  tpol_pkg::cmd_t cmd;
  tpol_pkg::sts_t sts;

  tpol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (in_data_i.opcode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tpol_dp #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // Checks
  `TPOL_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.accept, cmd.root_step, cmd.node_step, cmd.load_out}), "more than one datapath command")
  `TPOL_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid_o || !out_stall_i, "result loaded over a stalled beat")
  `TPOL_ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid_o, "loaded result not presented")
  `TPOL_ASSERT_NOW(a_found_ok, out_valid_o, out_data_o.found == (out_data_o.origin_asn != '0), "found flag disagrees with origin")

endmodule
